[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge out of reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/clnwq_pkg.sv]
// shared types and constants of the character display write queue
package clnwq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 9;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CF_PTR_W       = $clog2(CMD_FIFO_DEPTH);
    localparam int CF_CNT_W       = $clog2(CMD_FIFO_DEPTH + 1);

    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_CMD     = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic [2:0] STATUS_ENQUEUED = 3'd0;
    localparam logic [2:0] STATUS_DROPPED  = 3'd1;
    localparam logic [2:0] STATUS_BUSY     = 3'd2;
    localparam logic [2:0] STATUS_EMPTY    = 3'd3;
    localparam logic [2:0] STATUS_SENT     = 3'd4;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_BUSY,
        OP_TICK
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic [7:0]  data;
        logic        is_cmd;
    } op_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             idle;
    } back_stat_t;

endpackage

[src/clnwq_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module clnwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/clnwq_front.sv]
// front end: takes requests and turns them into queue operations
module clnwq_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [7:0]        byte_value,
    input  logic              busy_flag,
    input  logic              fifo_full,
    output logic              push,
    output clnwq_pkg::op_t    push_op
);
    import clnwq_pkg::*;

    logic known_kind;

    assign in_ready   = !fifo_full;
    assign known_kind = (kind == KIND_TEXT) || (kind == KIND_CMD) || (kind == KIND_TICK);
    // unused kind code is swallowed without a result
    assign push       = in_valid && in_ready && known_kind;

    always_comb
    begin
        push_op.data   = byte_value;
        push_op.is_cmd = (kind == KIND_CMD);
        case (kind)
            KIND_TEXT, KIND_CMD: push_op.code = OP_ENQ;
            KIND_TICK:           push_op.code = busy_flag ? OP_BUSY : OP_TICK;
            default:             push_op.code = OP_ENQ;
        endcase
    end

endmodule

[src/clnwq_cmd_fifo.sv]
// short operation queue between front and back end
module clnwq_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  clnwq_pkg::op_t    push_op,
    output logic              full,
    input  logic              pop,
    output clnwq_pkg::op_t    pop_op,
    output logic              empty
);
    import clnwq_pkg::*;

    op_t                 entries_reg [CMD_FIFO_DEPTH];
    logic [CF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CF_CNT_W-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CF_CNT_W'(CMD_FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CF_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CF_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[src/clnwq_back.sv]
// back end: ring queue bookkeeping, entry fetch and nibble sequencing
module clnwq_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    input  clnwq_pkg::op_t        op,
    output logic                  op_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [3:0]            nibble,
    output logic                  reg_select,
    output logic                  last,
    output clnwq_pkg::back_stat_t stat
);
    import clnwq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOW
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [3:0]       nibble_reg, nibble_next;
    logic             rs_reg, rs_next;
    logic             last_reg, last_next;
    logic [3:0]       low_reg, low_next;

    logic               out_free;
    logic               ram_wr_en, ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;

    clnwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wptr_reg),
        .wr_data ({op.is_cmd, op.data}),
        .rd_en   (ram_rd_en),
        .rd_addr (rptr_reg),
        .rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        rptr_next      = rptr_reg;
        wptr_next      = wptr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        nibble_next    = nibble_reg;
        rs_next        = rs_reg;
        last_next      = last_reg;
        low_next       = low_reg;
        op_pop         = 1'b0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_pop         = 1'b1;
                    out_valid_next = 1'b1;
                    nibble_next    = 4'd0;
                    rs_next        = 1'b0;
                    last_next      = 1'b1;
                    case (op.code)
                        OP_ENQ:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = STATUS_DROPPED;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                wptr_next   = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                              : wptr_reg + 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = STATUS_ENQUEUED;
                            end
                        end
                        OP_BUSY:
                        begin
                            status_next = STATUS_BUSY;
                        end
                        OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // no result yet: wait for the entry to come out of the ram
                                out_valid_next = out_valid_reg && !out_ready;
                                ram_rd_en      = 1'b1;
                                rptr_next      = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                 : rptr_reg + 1'b1;
                                count_next     = count_reg - 1'b1;
                                state_next     = S_FETCH;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_SENT;
                    nibble_next    = ram_rd_data[7:4];
                    rs_next        = !ram_rd_data[8];
                    last_next      = 1'b0;
                    low_next       = ram_rd_data[3:0];
                    state_next     = S_LOW;
                end
            end
            S_LOW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_SENT;
                    nibble_next    = low_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_ENQUEUED;
            nibble_reg    <= '0;
            rs_reg        <= 1'b0;
            last_reg      <= 1'b0;
            low_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            nibble_reg    <= nibble_next;
            rs_reg        <= rs_next;
            last_reg      <= last_next;
            low_reg       <= low_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign nibble     = nibble_reg;
    assign reg_select = rs_reg;
    assign last       = last_reg;
    assign stat.count = count_reg;
    assign stat.idle  = (state_reg == S_IDLE);

endmodule

[src/char_lcd_nibble_write_queue_unit.sv]
// top level of the character display write queue with a 4-bit bus
`include "assert_macros.svh"

// Character display write queue. Each request is a text byte, a command byte
// or a tick that carries the display's sampled busy flag. Bytes go into a ring
// queue of QUEUE_DEPTH entries held in a ram; a byte offered to a full queue is
// dropped and answered with the dropped status. A tick with busy set answers
// busy, a ready tick on an empty queue answers empty, and a ready tick on a
// non-empty queue sends the oldest entry as two results, upper nibble first,
// with reg_select low for commands and last set on the second one. An unused
// kind code is absorbed and gives no result. Timing: a two-deep operation
// queue decouples the request side from the result side, so requests are taken
// while results wait, until that queue fills. The back end answers a request
// with a single result from its idle state; a send goes through a fetch state
// for the registered ram read and then shows each nibble in turn, every step
// waiting while the result register is held. The queue contents need no
// clearing after reset; only pointers, counts, state and outputs are reset.
module char_lcd_nibble_write_queue_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] byte_value,
    input  logic       busy_flag,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [3:0] nibble,
    output logic       reg_select,
    output logic       last
);
    import clnwq_pkg::*;

    // front to queue
    logic       push;
    op_t        push_op;
    logic       fifo_full;

    // queue to back
    logic       fifo_empty;
    logic       op_pop;
    op_t        pop_op;

    back_stat_t stat;

    // upper nibble of a send currently shown on the result side
    logic       high_shown;

    clnwq_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .busy_flag  (busy_flag),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_op    (push_op)
    );

    clnwq_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (fifo_full),
        .pop     (op_pop),
        .pop_op  (pop_op),
        .empty   (fifo_empty)
    );

    // back end owns the ring queue and the result register
    clnwq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (!fifo_empty),
        .op         (pop_op),
        .op_pop     (op_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .nibble     (nibble),
        .reg_select (reg_select),
        .last       (last),
        .stat       (stat)
    );

    assign high_shown = out_valid && (status == STATUS_SENT) && !last;

    // fill count never passes the queue depth
    `ASSERT_ALWAYS(a_count_bound, stat.count <= CNT_W'(QUEUE_DEPTH))
    // upper nibble taken means the lower nibble of the same entry is shown next
    `ASSERT_NEXT(a_low_follows, high_shown && out_ready, out_valid && status == STATUS_SENT && last)
    // status-only results carry zero data and close their request
    `ASSERT_IMPLIES(a_plain_result, out_valid && status != STATUS_SENT, last && nibble == 4'd0 && !reg_select)
    // an upper nibble is never pending while the back end is idle
    `ASSERT_IMPLIES(a_idle_no_high, stat.idle, !high_shown)

endmodule
